// File: rtl/annexb_parameter_set_extractor_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Annex-B extractor.
// ----------------------------------------------------------------------------
`ifndef ANNEXB_PARAMETER_SET_EXTRACTOR_DEFINES_SVH
`define ANNEXB_PARAMETER_SET_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define ABPSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define ABPSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/abpse_pkg.sv
// ----------------------------------------------------------------------------
// Annex-B extractor package
// Item types, parser state, result bundle and NAL kind decode.
// ----------------------------------------------------------------------------
package abpse_pkg;

  localparam int unsigned LOOKBACK_DEPTH = 4;
  localparam int unsigned MAX_BYTES      = 5;

  localparam logic [2:0] CODE_LEN_3 = 3'd3;
  localparam logic [2:0] CODE_LEN_4 = 3'd4;

  localparam logic [4:0] H264_TYPE_SPS = 5'd7;
  localparam logic [4:0] H264_TYPE_PPS = 5'd8;
  localparam logic [5:0] H265_TYPE_VPS = 6'd32;
  localparam logic [5:0] H265_TYPE_SPS = 6'd33;
  localparam logic [5:0] H265_TYPE_PPS = 6'd34;

  localparam logic [2:0] KIND_FIRST  = 3'b001;
  localparam logic [2:0] KIND_SECOND = 3'b010;
  localparam logic [2:0] KIND_THIRD  = 3'b100;
  localparam logic [2:0] KIND_NONE   = 3'b000;

  localparam logic [2:0] REG_CODEC_IS_H265 = 3'd0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic [2:0] found_mask;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                           zero_run;
    logic [LOOKBACK_DEPTH-1:0][7:0]       lb;
    logic [2:0]                           lc;
    logic                                 ah;
    logic                                 kn;
    logic [2:0]                           cl;
    logic [2:0]                           fk;
  } parse_state_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                nbytes;
    logic                      fin;
    logic [2:0]                mask;
  } result_set_t;

  function automatic logic [2:0] kind_of(input logic [7:0] hdr, input logic h265);
    logic [2:0] k;
    k = KIND_NONE;
    if (!h265) begin
      if (hdr[4:0] == H264_TYPE_SPS) k = KIND_FIRST;
      else if (hdr[4:0] == H264_TYPE_PPS) k = KIND_SECOND;
    end else begin
      if (hdr[6:1] == H265_TYPE_VPS) k = KIND_FIRST;
      else if (hdr[6:1] == H265_TYPE_SPS) k = KIND_SECOND;
      else if (hdr[6:1] == H265_TYPE_PPS) k = KIND_THIRD;
    end
    return k;
  endfunction

endpackage

// File: rtl/abpse_step.sv
// ----------------------------------------------------------------------------
// Annex-B extractor step
// Next parser state and the result bundle for one input byte.
// ----------------------------------------------------------------------------
module abpse_step (
  input  abpse_pkg::parse_state_t cur_i,
  input  abpse_pkg::in_item_t     item_i,
  input  logic                    h265_i,
  output abpse_pkg::parse_state_t nxt_o,
  output abpse_pkg::result_set_t  res_o
);
  import abpse_pkg::*;

  logic [7:0]                     b;
  logic                           eob;
  logic [2:0]                     flag;
  logic                           keep;
  logic                           len4;
  logic [2:0]                     base;
  logic [2:0]                     lc_cap;
  logic [LOOKBACK_DEPTH-1:0][7:0] src;
  logic [2:0]                     cnt;
  logic                           extra_en;
  logic [7:0]                     extra;
  parse_state_t                   nxt;

  assign b      = item_i.in_byte;
  assign eob    = item_i.buffer_end;
  assign flag   = kind_of(b, h265_i);
  assign keep   = ((cur_i.cl == CODE_LEN_4) || !eob) && (flag != KIND_NONE)
                  && ((cur_i.fk & flag) == KIND_NONE);
  assign len4   = (cur_i.zero_run == 2'd3);
  assign lc_cap = (cur_i.lc > 3'd4) ? 3'd4 : cur_i.lc;
  assign base   = (cur_i.lc >= 3'd3) ? 3'd2 : cur_i.lc;

  always_comb begin
    nxt      = cur_i;
    src      = cur_i.lb;
    cnt      = 3'd0;
    extra_en = 1'b0;
    extra    = b;

    if (cur_i.ah) begin
      if (keep) begin
        nxt.fk   = cur_i.fk | flag;
        nxt.kn   = 1'b1;
        cnt      = lc_cap;
        extra_en = 1'b1;
      end else begin
        nxt.kn = 1'b0;
      end
      nxt.ah = 1'b0;
      nxt.cl = 3'd0;
      nxt.lc = 3'd0;
      if (b == 8'd0) begin
        nxt.lb[0]    = 8'd0;
        nxt.lc       = 3'd1;
        nxt.zero_run = 2'd1;
      end else begin
        nxt.zero_run = 2'd0;
      end
    end else if (b == 8'd0) begin
      if (cur_i.lc >= 3'd3) begin
        nxt.lb[0] = cur_i.lb[1];
        nxt.lb[1] = cur_i.lb[2];
      end
      nxt.lb[base[1:0]] = 8'd0;
      nxt.lc            = base + 3'd1;
      if (cur_i.zero_run != 2'd3) nxt.zero_run = cur_i.zero_run + 2'd1;
      if (cur_i.kn) begin
        if (eob) begin
          cnt      = (cur_i.lc >= 3'd3) ? 3'd3 : cur_i.lc;
          extra_en = 1'b1;
          extra    = 8'd0;
        end else if (cur_i.lc >= 3'd3) begin
          cnt = 3'd1;
        end
      end
    end else if ((b == 8'd1) && (cur_i.zero_run >= 2'd2)) begin
      nxt.lb[0] = 8'd0;
      nxt.lb[1] = 8'd0;
      if (len4) begin
        nxt.lb[2] = 8'd0;
        nxt.lb[3] = 8'd1;
        nxt.lc    = eob ? 3'd0 : CODE_LEN_4;
        nxt.cl    = CODE_LEN_4;
      end else begin
        nxt.lb[2] = 8'd1;
        nxt.lc    = CODE_LEN_3;
        nxt.cl    = CODE_LEN_3;
      end
      nxt.ah       = 1'b1;
      nxt.zero_run = 2'd0;
      // short code at buffer end stays in the current NAL
      if (eob && cur_i.kn && !len4) begin
        src[0] = 8'd0;
        src[1] = 8'd0;
        src[2] = 8'd1;
        cnt    = 3'd3;
      end
    end else begin
      if (cur_i.kn) begin
        cnt      = lc_cap;
        extra_en = 1'b1;
      end
      nxt.lc       = 3'd0;
      nxt.zero_run = 2'd0;
    end
  end

  always_comb begin
    res_o.bytes = {extra, src};
    if (extra_en) res_o.bytes[cnt] = extra;
    res_o.nbytes = cnt + {2'd0, extra_en};
    res_o.fin    = eob;
    res_o.mask   = nxt.fk;
  end

  always_comb begin
    nxt_o = nxt;
    if (eob) nxt_o = '0;
  end

endmodule

// File: rtl/annexb_parameter_set_extractor.sv
// ----------------------------------------------------------------------------
// Annex-B parameter-set extractor
// Forwards the first SPS/PPS (and VPS) NAL of each buffer, start code kept.
// Latency: an item's first result is offered the cycle after it is accepted.
// Throughput: one item per cycle while each item yields at most one result and
// the output is not stalled; an item yielding k results (k up to 6) holds the
// input off while the result register drains them, one per unstalled cycle.
// Reset: parser state, result register and codec_is_h265 clear at once.
// ----------------------------------------------------------------------------
`include "annexb_parameter_set_extractor_defines.svh"

module annexb_parameter_set_extractor (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  abpse_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output abpse_pkg::out_item_t out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import abpse_pkg::*;

  parse_state_t state_q, state_d;
  result_set_t  res_q, res_d;
  logic         busy_q;
  logic [2:0]   rd_q;
  logic [2:0]   tot_q;
  logic [2:0]   tot_d;
  logic         codec_q;
  logic         in_acc;
  logic         out_take;
  logic         last_take;
  logic         cfg_wr;
  logic         end_acc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr == REG_CODEC_IS_H265) ? {31'd0, codec_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q <= 1'b0;
    end else if (cfg_wr && (paddr == REG_CODEC_IS_H265)) begin
      codec_q <= pwdata[0];
    end
  end

  abpse_step u_step (
    .cur_i  (state_q),
    .item_i (in_item_i),
    .h265_i (codec_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  assign tot_q     = res_q.nbytes + {2'd0, res_q.fin};
  assign tot_d     = res_d.nbytes + {2'd0, res_d.fin};
  assign out_take  = busy_q && !out_stall_i;
  assign last_take = out_take && (rd_q == tot_q - 3'd1);
  assign in_stall_o = busy_q && !last_take;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign end_acc   = in_acc && in_item_i.buffer_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rd_q   <= 3'd0;
    end else if (in_acc && (tot_d != 3'd0)) begin
      busy_q <= 1'b1;
      rd_q   <= 3'd0;
    end else if (last_take) begin
      busy_q <= 1'b0;
      rd_q   <= 3'd0;
    end else if (out_take) begin
      rd_q <= rd_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (in_acc && (tot_d != 3'd0)) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    out_valid_o           = busy_q;
    out_item_o.found_mask = res_q.mask;
    if (rd_q < res_q.nbytes) begin
      out_item_o.out_byte   = res_q.bytes[rd_q];
      out_item_o.byte_valid = 1'b1;
      out_item_o.run_last   = 1'b0;
    end else begin
      out_item_o.out_byte   = 8'd0;
      out_item_o.byte_valid = 1'b0;
      out_item_o.run_last   = 1'b1;
    end
  end

  `ABPSE_ASSERT(a_hold_input, (busy_q && out_stall_i) |-> in_stall_o, "input taken while held")
  `ABPSE_ASSERT(a_rd_range, busy_q |-> (rd_q < tot_q), "result index past bundle")
  `ABPSE_ASSERT_NEXT(a_end_clears, end_acc, (state_q == '0), "state kept past buffer end")
  `ABPSE_ASSERT_NEXT(a_end_final, end_acc, busy_q && res_q.fin, "final item missing")

endmodule
